FILE: rtl/apdf_pkg.sv
// Shared types, codes and constants of the alarm proximity filter.
`default_nettype none
package apdf_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int POS_W   = 32;
  localparam int KIND_W  = 3;
  localparam int TOL_W   = 20;
  localparam int ACT_W   = 2;
  localparam int REG_IDX_W = 1;
  localparam int IN_DATA_W  = 2 * POS_W;
  localparam int OUT_DATA_W = 8;

  localparam logic [TOL_W-1:0] SLIDE_TOL_RST   = TOL_W'(2000);
  localparam logic [TOL_W-1:0] SPINDLE_TOL_RST = TOL_W'(280);

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_SLIDE_TOL   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SPINDLE_TOL = 1'b1;

  // alarm types
  localparam logic [KIND_W-1:0] KIND_FOLDBACK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NORMAL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GAP      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_XERR     = 3'd5;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE     = 2'd0,
    ACT_FOLDBACK = 2'd1,
    ACT_GAP      = 2'd2,
    ACT_XERR     = 2'd3
  } apdf_act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } apdf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input item
    logic rd_en;   // read the next table entry
    logic finish;  // form the result, update the table
  } apdf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;  // type 1..3 and the table holds something
    logic last_rd;    // the read being issued is of the last valid entry
    logic out_free;   // output register can take a result
  } apdf_sts_t;

endpackage
`default_nettype wire

FILE: rtl/apdf_ctrl.sv
// Controller state machine: accept, table scan, result hand-off.
`default_nettype none
module apdf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire apdf_pkg::apdf_sts_t sts,
  output apdf_pkg::apdf_cmd_t     cmd
);
  import apdf_pkg::*;

  apdf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.need_scan) state_nxt = ST_DONE;
        else if (sts.last_rd) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.rd_en = sts.need_scan;
      end
      ST_DRAIN: begin
        // last compare lands this cycle
      end
      ST_DONE: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/apdf_dpath.sv
// Datapath: tolerance registers, crossing table, window compare, result register.
`default_nettype none
module apdf_dpath #(
  parameter int TABLE_DEPTH = apdf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [apdf_pkg::REG_IDX_W-1:0]      cfg_addr,
  input  wire logic [apdf_pkg::TOL_W-1:0]          cfg_wdata,
  input  wire logic [apdf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [apdf_pkg::KIND_W-1:0]         in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [apdf_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire apdf_pkg::apdf_cmd_t                 cmd,
  output apdf_pkg::apdf_sts_t                      sts
);
  import apdf_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = 2 * POS_W;

  // |a - b| < tol, done as two sign checks on a - b -/+ tol
  function automatic logic within_tol(input logic [POS_W-1:0] a,
                                      input logic [POS_W-1:0] b,
                                      input logic [TOL_W-1:0] tol);
    logic signed [POS_W+1:0] d;
    logic signed [POS_W+1:0] hi;
    logic signed [POS_W+1:0] lo;
    d  = $signed({{2{a[POS_W-1]}}, a}) - $signed({{2{b[POS_W-1]}}, b});
    hi = d - $signed({{(POS_W+2-TOL_W){1'b0}}, tol});
    lo = d + $signed({{(POS_W+2-TOL_W){1'b0}}, tol});
    return hi[POS_W+1] && !lo[POS_W+1] && (lo != '0);
  endfunction

  logic [TOL_W-1:0]  slide_tol_r;
  logic [TOL_W-1:0]  spin_tol_r;
  logic [KIND_W-1:0] kind_r;
  logic [POS_W-1:0]  slide_r;
  logic [POS_W-1:0]  spin_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic [ENT_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic              hit_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [ENT_W-1:0]  tbl_mem [TABLE_DEPTH];

  logic              kind_123;
  logic              entry_match;
  logic              has_room;
  logic              wr_en;
  logic              res_stored;
  logic              res_full;
  apdf_act_t         res_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slide_tol_r <= SLIDE_TOL_RST;
      spin_tol_r  <= SPINDLE_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SLIDE_TOL:   slide_tol_r <= cfg_wdata;
        REG_SPINDLE_TOL: spin_tol_r  <= cfg_wdata;
        default:         slide_tol_r <= slide_tol_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_tuser;
      slide_r <= in_tdata[POS_W-1:0];
      spin_r  <= in_tdata[ENT_W-1:POS_W];
    end
  end

  assign kind_123 = (kind_r == KIND_FOLDBACK) || (kind_r == KIND_NORMAL) ||
                    (kind_r == KIND_OTHER);
  assign has_room = (count_r < CNT_W'(TABLE_DEPTH));

  assign sts.need_scan = kind_123 && (count_r != '0);
  assign sts.last_rd   = ({{(CNT_W-IDX_W){1'b0}}, scan_idx_r} == (count_r - CNT_W'(1)));
  assign sts.out_free  = !out_valid_r || out_tready;

  // scan: one entry read a cycle, compared the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.load) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
      end else begin
        if (cmd.rd_en) scan_idx_r <= scan_idx_r + IDX_W'(1);
        if (rd_vld_r && entry_match) hit_r <= 1'b1;
      end
    end
  end

  assign entry_match = within_tol(rd_data_r[ENT_W-1:POS_W], slide_r, slide_tol_r) &&
                       within_tol(rd_data_r[POS_W-1:0], spin_r, spin_tol_r);

  assign wr_en = cmd.finish && (kind_r == KIND_NORMAL) && !hit_r && has_room;

  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[count_r[IDX_W-1:0]] <= {slide_r, spin_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data_r <= tbl_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_comb begin
    res_stored = (kind_r == KIND_NORMAL) && !hit_r && has_room;
    res_full   = (kind_r == KIND_NORMAL) && !hit_r && !has_room;
    priority if ((kind_r == KIND_FOLDBACK) && !hit_r) res_act = ACT_FOLDBACK;
    else if (kind_r == KIND_GAP)                       res_act = ACT_GAP;
    else if (kind_r == KIND_XERR)                      res_act = ACT_XERR;
    else                                               res_act = ACT_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= {3'b000, res_full, res_stored, res_act, kind_123 && hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/alarm_proximity_dedup_filter.sv
// Top level of the alarm proximity filter: controller plus datapath.
`default_nettype none
// Takes one defect alarm per item and returns one result item. Alarms of type
// 1 to 3 are compared against every stored normal-crossing position; a hit
// within both tolerances suppresses the alarm, otherwise a type 2 alarm is
// appended to the table (or table_full is flagged). Items are handled one at a
// time: an item of type 1 to 3 is scanned against the N stored entries, which
// are read one entry per cycle from the single table memory; other types, and
// an empty table, skip the scan. The next item may be accepted while the
// previous result still waits on the output. The table needs no clearing pass:
// the entry count is cleared by reset.
module alarm_proximity_dedup_filter #(
  parameter int TABLE_DEPTH = apdf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [apdf_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire logic [apdf_pkg::TOL_W-1:0]     cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [31:0] slide_pos, [63:32] spindle_pos
  input  wire logic [apdf_pkg::IN_DATA_W-1:0] in_tdata,
  // [2:0] kind
  input  wire logic [apdf_pkg::KIND_W-1:0]    in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] suppressed, [2:1] action, [3] stored, [4] table_full, [7:5] zero
  output logic [apdf_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import apdf_pkg::*;

  apdf_cmd_t cmd;
  apdf_sts_t sts;

  apdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  apdf_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire
